@@ design/permutation_pair_cycle_counter_macros.svh @@
`ifndef PERMUTATION_PAIR_CYCLE_COUNTER_MACROS_SVH
`define PERMUTATION_PAIR_CYCLE_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define PPCC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define PPCC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ppcc_pkg.sv @@
package ppcc_pkg;

  localparam int VAL_W  = 11;
  localparam int PROD_W = 30;

  localparam logic [PROD_W:0] MODULUS = 31'd1000000007;

  // One store entry: slot written, node visited, successor value.
  typedef struct packed {
    logic             written;
    logic             visited;
    logic [VAL_W-1:0] succ;
  } ppcc_entry_t;

  typedef struct packed {
    logic init;   // clearing pass after reset
    logic load;   // take an input item
    logic store;  // check and store the latched pair
    logic setup;  // close the set, start the scan
    logic scan;   // scan entry data is on the read port
    logic walk;   // walk node data is on the read port
    logic emit;   // load the result register, clear the set
  } ppcc_cmd_t;

  typedef struct packed {
    logic init_last;
    logic last;
    logic follow;
    logic scan_last;
  } ppcc_stat_t;

endpackage

@@ design/ppcc_if.sv @@
interface ppcc_pair_if;
  logic                       valid;
  logic                       ready;
  logic [ppcc_pkg::VAL_W-1:0] top_value;
  logic [ppcc_pkg::VAL_W-1:0] bottom_value;
  logic                       last_pair;

  modport source (output valid, top_value, bottom_value, last_pair, input ready);
  modport sink (input valid, top_value, bottom_value, last_pair, output ready);
endinterface

interface ppcc_result_if;
  logic                        valid;
  logic                        ready;
  logic [ppcc_pkg::VAL_W-1:0]  cycle_count;
  logic [ppcc_pkg::PROD_W-1:0] arrangement_count;
  logic                        bad_input;

  modport source (output valid, cycle_count, arrangement_count, bad_input, input ready);
  modport sink (input valid, cycle_count, arrangement_count, bad_input, output ready);
endinterface

@@ design/ppcc_ctrl.sv @@
`include "permutation_pair_cycle_counter_macros.svh"

module ppcc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  ppcc_pkg::ppcc_stat_t stat_i,
  output ppcc_pkg::ppcc_cmd_t  cmd_o
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LCHK  = 3'd2;
  localparam logic [2:0] S_SETUP = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_WALK  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.init = 1'b1;
        if (stat_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LCHK;
        end
      end
      S_LCHK: begin
        cmd_o.store = 1'b1;
        state_d     = stat_i.last ? S_SETUP : S_IDLE;
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = S_SCAN;
      end
      S_SCAN, S_WALK: begin
        cmd_o.scan = (state_q == S_SCAN);
        cmd_o.walk = (state_q == S_WALK);
        priority if (stat_i.follow) begin
          state_d = S_WALK;
        end else if (stat_i.scan_last) begin
          state_d = S_FIN;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_FIN: begin
        // hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `PPCC_ASSERT_IMP(a_emit_free, cmd_o.emit, !out_valid_q || out_ready_i, "result overwritten")
  `PPCC_ASSERT_NXT(a_load_check, in_valid_i && in_ready_o, state_q == S_LCHK, "pair not checked")
  `PPCC_ASSERT_NXT(a_emit_shown, cmd_o.emit, out_valid_o && state_q == S_IDLE, "result not shown")

endmodule

@@ design/ppcc_dp.sv @@
`include "permutation_pair_cycle_counter_macros.svh"

module ppcc_dp #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ppcc_pkg::ppcc_cmd_t         cmd_i,
  output ppcc_pkg::ppcc_stat_t        stat_o,
  input  logic [ppcc_pkg::VAL_W-1:0]  top_value_i,
  input  logic [ppcc_pkg::VAL_W-1:0]  bottom_value_i,
  input  logic                        last_pair_i,
  output logic [ppcc_pkg::VAL_W-1:0]  cycle_count_o,
  output logic [ppcc_pkg::PROD_W-1:0] arrangement_count_o,
  output logic                        bad_input_o
);

  localparam int VW = ppcc_pkg::VAL_W;
  localparam int PW = ppcc_pkg::PROD_W;
  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int KW = (CW > VW) ? CW : VW;
  localparam logic [KW-1:0] MAX_K = KW'(MAX_COLUMNS);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_COLUMNS);

  function automatic logic [AW-1:0] to_idx(input logic [KW-1:0] v);
    logic [KW-1:0] t;
    t = v - KW'(1);
    return t[AW-1:0];
  endfunction

  ppcc_pkg::ppcc_entry_t mem_q [MAX_COLUMNS];
  ppcc_pkg::ppcc_entry_t rdata_q;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          err_q, err_d;
  logic [VW-1:0] maxtop_q, maxtop_d;
  logic [VW-1:0] maxbot_q, maxbot_d;
  logic [CW-1:0] scan_q, scan_d;
  logic          last_q, last_d;
  logic [VW-1:0] top_q, top_d;
  logic [VW-1:0] bot_q, bot_d;
  logic [KW-1:0] node_q, node_d;
  logic [CW-1:0] lim_q, lim_d;
  logic [VW-1:0] cyc_q, cyc_d;
  logic [PW-1:0] prod_q, prod_d;
  logic [VW-1:0] ocyc_q, ocyc_d;
  logic [PW-1:0] oprod_q, oprod_d;
  logic          obad_q, obad_d;

  logic [KW-1:0] scan_k, cnt_k, top_k, bot_k, nxt_k, cur_k, in_top_k, mtop_k, mbot_k;
  logic          cur_ok, nxt_ok, follow, scan_last, advance;
  logic          ovf, rng_ok, store_ok;
  logic [PW:0]   dbl;
  logic [PW:0]   dbl_red;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_wa, mem_ra;
  ppcc_pkg::ppcc_entry_t mem_wd;

  assign scan_k   = KW'(scan_q);
  assign cnt_k    = KW'(cnt_q);
  assign top_k    = KW'(top_q);
  assign bot_k    = KW'(bot_q);
  assign nxt_k    = KW'(rdata_q.succ);
  assign in_top_k = KW'(top_value_i);
  assign mtop_k   = KW'(maxtop_q);
  assign mbot_k   = KW'(maxbot_q);
  assign cur_k    = cmd_i.walk ? node_q : scan_k;

  // every node at or below the scan index already counts as visited
  assign cur_ok = !rdata_q.visited && (cmd_i.walk || scan_k <= cnt_k);
  assign nxt_ok = (nxt_k != '0) && (nxt_k <= cnt_k) && (nxt_k > scan_k) && (nxt_k != cur_k);
  assign follow    = (cmd_i.scan || cmd_i.walk) && cur_ok && rdata_q.written && nxt_ok;
  assign scan_last = (scan_q == lim_q);
  assign advance   = (cmd_i.scan || cmd_i.walk) && !follow && !scan_last;

  assign ovf      = (cnt_q == MAX_C);
  assign rng_ok   = (top_k != '0) && (top_k <= MAX_K) && (bot_k != '0) && (bot_k <= MAX_K);
  assign store_ok = cmd_i.store && !ovf && rng_ok && !rdata_q.written;

  assign dbl     = {prod_q, 1'b0};
  assign dbl_red = (dbl >= ppcc_pkg::MODULUS) ? dbl - ppcc_pkg::MODULUS : dbl;

  assign stat_o.init_last = (scan_q == MAX_C);
  assign stat_o.last      = last_q;
  assign stat_o.follow    = follow;
  assign stat_o.scan_last = scan_last;

  always_comb begin
    cnt_d    = cnt_q;
    err_d    = err_q;
    maxtop_d = maxtop_q;
    maxbot_d = maxbot_q;
    scan_d   = scan_q;
    last_d   = last_q;
    top_d    = top_q;
    bot_d    = bot_q;
    node_d   = node_q;
    lim_d    = lim_q;
    cyc_d    = cyc_q;
    prod_d   = prod_q;
    ocyc_d   = ocyc_q;
    oprod_d  = oprod_q;
    obad_d   = obad_q;

    if (cmd_i.init && !stat_o.init_last) begin
      scan_d = scan_q + CW'(1);
    end
    if (cmd_i.load) begin
      top_d  = top_value_i;
      bot_d  = bottom_value_i;
      last_d = last_pair_i;
    end
    if (cmd_i.store) begin
      if (ovf) begin
        err_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CW'(1);
        if (!rng_ok || rdata_q.written) begin
          err_d = 1'b1;
        end
      end
    end
    if (store_ok) begin
      if (top_q > maxtop_q) begin
        maxtop_d = top_q;
      end
      if (bot_q > maxbot_q) begin
        maxbot_d = bot_q;
      end
    end
    if (cmd_i.setup) begin
      if (mtop_k > cnt_k || mbot_k > cnt_k) begin
        err_d = 1'b1;
      end
      // scan far enough to clear every stored slot
      lim_d  = (mtop_k > cnt_k) ? CW'(maxtop_q) : cnt_q;
      scan_d = CW'(1);
      cyc_d  = '0;
      prod_d = PW'(1);
    end
    if (cmd_i.scan && cur_ok) begin
      cyc_d  = cyc_q + VW'(1);
      prod_d = dbl_red[PW-1:0];
    end
    if (follow) begin
      node_d = nxt_k;
    end
    if (advance) begin
      scan_d = scan_q + CW'(1);
    end
    if (cmd_i.emit) begin
      ocyc_d   = cyc_q;
      oprod_d  = prod_q;
      obad_d   = err_q;
      cnt_d    = '0;
      err_d    = 1'b0;
      maxtop_d = '0;
      maxbot_d = '0;
    end
  end

  always_comb begin
    mem_re = 1'b1;
    mem_ra = '0;
    if (cmd_i.load) begin
      mem_ra = to_idx(in_top_k);
    end else if (follow) begin
      mem_ra = to_idx(nxt_k);
    end else if (advance) begin
      mem_ra = scan_k[AW-1:0];
    end else begin
      mem_re = cmd_i.setup;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = to_idx(scan_k);
    mem_wd = '0;
    if (cmd_i.init || cmd_i.scan) begin
      mem_we = 1'b1;
    end else if (store_ok) begin
      mem_we = 1'b1;
      mem_wa = to_idx(top_k);
      mem_wd = '{written: 1'b1, visited: 1'b0, succ: bot_q};
    end else if (cmd_i.walk && cur_ok) begin
      mem_we = 1'b1;
      mem_wa = to_idx(node_q);
      mem_wd = '{written: rdata_q.written, visited: 1'b1, succ: rdata_q.succ};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      // pass a same-cycle write straight through to the read port
      rdata_q <= (mem_we && (mem_wa == mem_ra)) ? mem_wd : mem_q[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      err_q    <= 1'b0;
      maxtop_q <= '0;
      maxbot_q <= '0;
      scan_q   <= CW'(1);
      last_q   <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      err_q    <= err_d;
      maxtop_q <= maxtop_d;
      maxbot_q <= maxbot_d;
      scan_q   <= scan_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    bot_q   <= bot_d;
    node_q  <= node_d;
    lim_q   <= lim_d;
    cyc_q   <= cyc_d;
    prod_q  <= prod_d;
    ocyc_q  <= ocyc_d;
    oprod_q <= oprod_d;
    obad_q  <= obad_d;
  end

  assign cycle_count_o       = ocyc_q;
  assign arrangement_count_o = oprod_q;
  assign bad_input_o         = obad_q;

  `PPCC_ASSERT_IMP(a_walk_range, cmd_i.walk, node_q != '0 && node_q <= cnt_k && node_q > scan_k, "walk node out of range")
  `PPCC_ASSERT_IMP(a_scan_bound, cmd_i.scan || cmd_i.walk, scan_q <= lim_q, "scan ran past its limit")
  `PPCC_ASSERT_IMP(a_count_bound, cmd_i.store, cnt_q <= MAX_C, "pair count past the store depth")

endmodule

@@ design/permutation_pair_cycle_counter.sv @@
// Channel   Dir  Payload                                           Accepted when
// pair_i    in   top_value, bottom_value, last_pair                valid && ready
// result_o  out  cycle_count, arrangement_count, bad_input         valid && ready
//
// Each pair first reads its slot from the store, then is checked and written; a new pair is
// taken only after that. Closing a set runs a setup step, a scan of each store entry up to the
// larger of the pair count and the highest stored top value, and walk steps along each cycle found;
// scan and walk share the single read port. After reset all MAX_COLUMNS entries are cleared first.
// A result waits in its output register; a stalled result holds the next set at its close.
module permutation_pair_cycle_counter #(
  parameter int MAX_COLUMNS = 1024
) (
  input logic          clk_i,
  input logic          rst_ni,
  ppcc_pair_if.sink    pair_i,
  ppcc_result_if.source result_o
);

  ppcc_pkg::ppcc_cmd_t  cmd;
  ppcc_pkg::ppcc_stat_t stat;
  logic                 in_ready;
  logic                 out_valid;

  ppcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pair_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ppcc_dp #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .top_value_i         (pair_i.top_value),
    .bottom_value_i      (pair_i.bottom_value),
    .last_pair_i         (pair_i.last_pair),
    .cycle_count_o       (result_o.cycle_count),
    .arrangement_count_o (result_o.arrangement_count),
    .bad_input_o         (result_o.bad_input)
  );

  assign pair_i.ready   = in_ready;
  assign result_o.valid = out_valid;

endmodule
